/* design/crn_pkg.sv */
// shared types, constants and lookup tables of the cross-channel response normalizer
// no dependencies; used by every other file of the block

package crn_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 15;
	localparam int MAX_CHANNELS = 1024;
	localparam int DELAY_DEPTH = MAX_WINDOW / 2 + 1;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
	localparam int SUM_BITS    = SQ_BITS + $clog2(MAX_WINDOW);
	localparam int SIZE_BITS   = $clog2(MAX_WINDOW + 1);
	localparam int LAG_BITS    = $clog2(DELAY_DEPTH);
	localparam int COUNT_BITS  = $clog2(MAX_CHANNELS + 1);
	localparam int CI_BITS     = $clog2(MAX_CHANNELS);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA         = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_K_OFFSET      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BETA          = 3'd4;

	typedef struct packed {
		logic [SIZE_BITS-1:0] size;
		logic [LAG_BITS-1:0]  lag;
		logic [23:0]          alpha;
		logic [23:0]          k;
		logic [15:0]          beta;
	} crn_cfg_t;

	typedef struct packed {
		logic       push;
		logic       push_zero;
		logic       load;
		logic       mul_hi;
		logic       scale;
		logic       norm_step;
		logic [2:0] norm_idx;
		logic       log_step;
		logic       beta_step;
		logic       xmul;
		logic       out_write;
		logic       out_last;
		logic       clear;
	} crn_cmd_t;

	typedef logic [15:0] lg_tab_t [256];
	typedef logic [16:0] ex_tab_t [256];

	// 16 bits of log2 of a Q1.30 mantissa, by repeated squaring
	function automatic logic [15:0] lg16(logic [63:0] m_in);
		logic [63:0] m;
		logic [15:0] r;
		m = m_in;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			r = {r[14:0], 1'b0};
			if (m >= 64'h8000_0000) begin
				r[0] = 1'b1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	function automatic lg_tab_t build_lg();
		lg_tab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = lg16(64'(256 + i) << 22);
		return t;
	endfunction

	// smallest Q1.16 value whose log2 reaches g/256
	function automatic ex_tab_t build_ex();
		ex_tab_t t;
		logic [16:0] lo;
		logic [16:0] hi;
		logic [16:0] mid;
		for (int i = 0; i < 256; i++) begin
			lo = 17'd65536;
			hi = 17'd131071;
			for (int b = 0; b < 18; b++) begin
				if (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					if (lg16(64'(mid) << 14) >= 16'(i * 256)) hi = mid;
					else lo = mid + 17'd1;
				end
			end
			t[i] = lo;
		end
		return t;
	endfunction

	localparam lg_tab_t LG_TABLE = build_lg();
	localparam ex_tab_t EX_TABLE = build_ex();

endpackage

/* design/crn_if.sv */
// valid/ready channel interfaces of the response normalizer: samples, results, register writes
// depends on crn_pkg

interface crn_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [crn_pkg::SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface crn_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [crn_pkg::SAMPLE_BITS-1:0] normalized;
	logic                               last_of_pixel;
	modport source (output valid, output normalized, output last_of_pixel, input ready);
	modport sink (input valid, input normalized, input last_of_pixel, output ready);
endinterface

interface crn_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [crn_pkg::CFG_IDX_BITS-1:0]    index;
	logic [crn_pkg::CFG_DATA_BITS-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/crn_datapath.sv */
// datapath: square window, sample delay, running sum, scale/log/exp arithmetic, result register
// depends on crn_pkg

module crn_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  crn_pkg::crn_cmd_t                      cmd,
	input  crn_pkg::crn_cfg_t                      cfg,
	input  logic signed [crn_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   out_ready,
	output logic                                   out_free,
	output logic                                   out_valid,
	output logic signed [crn_pkg::SAMPLE_BITS-1:0] normalized,
	output logic                                   last_of_pixel
);

	logic [crn_pkg::SQ_BITS-1:0]  sq_win_q [crn_pkg::MAX_WINDOW];
	logic signed [crn_pkg::SAMPLE_BITS-1:0] delay_q [crn_pkg::DELAY_DEPTH];
	logic [crn_pkg::SUM_BITS-1:0] sum_q;

	logic signed [crn_pkg::SAMPLE_BITS-1:0] x_q;
	logic [16:0]                  sum_hi_q;
	logic [57:0]                  acc_q;
	logic [34:0]                  s_q;
	logic [5:0]                   cnt_q;
	logic signed [21:0]           lg_q;
	logic signed [19:0]           z_q;
	logic signed [11:0]           ip_q;
	logic signed [33:0]           v_q;
	logic                         out_valid_q;
	logic signed [crn_pkg::SAMPLE_BITS-1:0] norm_q;
	logic                         last_q;

	logic signed [crn_pkg::SAMPLE_BITS-1:0] push_x;
	logic signed [2*crn_pkg::SAMPLE_BITS-1:0] sq_full;
	logic [crn_pkg::SQ_BITS-1:0]  sq;
	logic [crn_pkg::SQ_BITS-1:0]  leaving;
	logic [crn_pkg::SIZE_BITS-1:0] tail_idx;
	logic [34:0]                  s_next;
	logic [35:0]                  scaled;
	logic [5:0]                   norm_amt;
	logic                         norm_zero;
	logic [5:0]                   exp_d;
	logic signed [38:0]           bprod;
	logic signed [39:0]           zt;
	logic signed [33:0]           xprod;
	logic signed [11:0]           sh_m1_w;
	logic [5:0]                   sh_m1;
	logic signed [33:0]           t1;
	logic signed [34:0]           r2;
	logic signed [crn_pkg::SAMPLE_BITS-1:0] res;

	localparam logic signed [crn_pkg::SAMPLE_BITS-1:0] SAT_HI =
		{1'b0, {(crn_pkg::SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [crn_pkg::SAMPLE_BITS-1:0] SAT_LO =
		{1'b1, {(crn_pkg::SAMPLE_BITS-1){1'b0}}};

	assign push_x   = cmd.push_zero ? '0 : sample;
	assign sq_full  = push_x * push_x;
	assign sq       = crn_pkg::SQ_BITS'(sq_full);
	assign tail_idx = cfg.size - crn_pkg::SIZE_BITS'(1);
	assign leaving  = sq_win_q[tail_idx[crn_pkg::SIZE_BITS-1:0]];

	// window and delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < crn_pkg::MAX_WINDOW; i++) sq_win_q[i] <= '0;
			for (int i = 0; i < crn_pkg::DELAY_DEPTH; i++) delay_q[i] <= '0;
			sum_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < crn_pkg::MAX_WINDOW; i++) sq_win_q[i] <= '0;
			for (int i = 0; i < crn_pkg::DELAY_DEPTH; i++) delay_q[i] <= '0;
			sum_q <= '0;
		end else if (cmd.push || cmd.push_zero) begin
			for (int i = crn_pkg::MAX_WINDOW - 1; i > 0; i--) sq_win_q[i] <= sq_win_q[i-1];
			sq_win_q[0] <= sq;
			for (int i = crn_pkg::DELAY_DEPTH - 1; i > 0; i--) delay_q[i] <= delay_q[i-1];
			delay_q[0] <= push_x;
			sum_q <= sum_q + crn_pkg::SUM_BITS'(sq) - crn_pkg::SUM_BITS'(leaving);
		end
	end

	// scale, normalization, log, beta and exp arithmetic
	always_comb begin
		scaled = 36'(acc_q + 58'd8388608 >> 24) + 36'(cfg.k);
		s_next = (scaled == '0) ? 35'd1 : 35'(scaled);
		case (cmd.norm_idx)
			3'd0: begin norm_amt = 6'd32; norm_zero = (s_q[34:3] == '0); end
			3'd1: begin norm_amt = 6'd16; norm_zero = (s_q[34:19] == '0); end
			3'd2: begin norm_amt = 6'd8; norm_zero = (s_q[34:27] == '0); end
			3'd3: begin norm_amt = 6'd4; norm_zero = (s_q[34:31] == '0); end
			3'd4: begin norm_amt = 6'd2; norm_zero = (s_q[34:33] == '0); end
			default: begin norm_amt = 6'd1; norm_zero = !s_q[34]; end
		endcase
		exp_d = 6'd18 - cnt_q;
		bprod = $signed({1'b0, cfg.beta}) * lg_q;
		zt    = 40'sd524288 - 40'(bprod);
		xprod = x_q * $signed({1'b0, crn_pkg::EX_TABLE[z_q[7:0]]});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= delay_q[cfg.lag];
			sum_hi_q <= sum_q[33:17];
			acc_q    <= 58'(cfg.alpha * sum_q[16:0]);
		end
		if (cmd.mul_hi)
			acc_q <= acc_q + (58'(cfg.alpha * sum_hi_q) << 17);
		if (cmd.scale) begin
			s_q   <= s_next;
			cnt_q <= '0;
		end
		if (cmd.norm_step && norm_zero) begin
			s_q   <= s_q << norm_amt;
			cnt_q <= cnt_q + norm_amt;
		end
		if (cmd.log_step)
			lg_q <= $signed({exp_d, crn_pkg::LG_TABLE[s_q[33:26]]});
		if (cmd.beta_step)
			z_q <= 20'(zt >>> 20);
		if (cmd.xmul) begin
			v_q  <= xprod;
			ip_q <= 12'(z_q >>> 8);
		end
	end

	// rounding shift and saturation
	always_comb begin
		sh_m1_w = 12'sd15 - ip_q;
		sh_m1   = sh_m1_w[5:0];
		t1      = v_q >>> sh_m1;
		r2      = (35'(t1) + 35'sd1) >>> 1;
		if (x_q == '0)
			res = '0;
		else if (ip_q >= 12'sd16)
			res = x_q[crn_pkg::SAMPLE_BITS-1] ? SAT_LO : SAT_HI;
		else if (ip_q <= -12'sd34)
			res = '0;
		else if (r2 > 35'(SAT_HI))
			res = SAT_HI;
		else if (r2 < 35'(SAT_LO))
			res = SAT_LO;
		else
			res = crn_pkg::SAMPLE_BITS'(r2);
	end

	// result register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_write)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_write) begin
			norm_q <= res;
			last_q <= cmd.out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign normalized    = norm_q;
	assign last_of_pixel = last_q;

endmodule

/* design/crn_ctrl.sv */
// controller: register file, channel bookkeeping and the sequencer of the arithmetic steps
// depends on crn_pkg

module crn_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cfg_valid,
	input  logic [crn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [crn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                out_free,
	output crn_pkg::crn_cmd_t                   cmd,
	output crn_pkg::crn_cfg_t                   cfg
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_SCALE, ST_NORM, ST_LOG,
		ST_BETA, ST_XMUL, ST_OUT, ST_FLUSH, ST_CLEAR
	} state_t;

	state_t state_q;
	logic [3:0]  size_q;
	logic [10:0] count_q;
	logic [23:0] alpha_q;
	logic [23:0] k_q;
	logic [15:0] beta_q;
	logic [crn_pkg::CI_BITS-1:0]  ci_q;
	logic [crn_pkg::LAG_BITS-1:0] j_q;
	logic [2:0]  norm_idx_q;
	logic        pix_last_q;
	logic        out_last_q;

	logic [crn_pkg::SIZE_BITS-1:0]  eff_size;
	logic [crn_pkg::COUNT_BITS-1:0] eff_count;
	logic [crn_pkg::LAG_BITS-1:0]   lag;
	logic [crn_pkg::LAG_BITS-1:0]   j_next;
	logic        in_acc;
	logic        last;
	logic        emit_now;
	logic        flush_emit;
	logic        cfg_clear;

	assign eff_size  = (size_q == '0) ? crn_pkg::SIZE_BITS'(1) : size_q;
	assign eff_count = (count_q == '0) ? crn_pkg::COUNT_BITS'(1) :
		(count_q > crn_pkg::COUNT_BITS'(crn_pkg::MAX_CHANNELS)) ?
		crn_pkg::COUNT_BITS'(crn_pkg::MAX_CHANNELS) : count_q;
	assign lag       = crn_pkg::LAG_BITS'(eff_size >> 1);
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign last      = ({1'b0, ci_q} + crn_pkg::COUNT_BITS'(1)) >= eff_count;
	assign emit_now  = ci_q >= crn_pkg::CI_BITS'(lag);
	assign j_next    = j_q + crn_pkg::LAG_BITS'(1);
	assign flush_emit = ({1'b0, ci_q} + crn_pkg::COUNT_BITS'(j_next)) >=
		crn_pkg::COUNT_BITS'(lag);
	assign cfg_clear = cfg_valid &&
		(cfg_index == crn_pkg::CFG_WINDOW_SIZE || cfg_index == crn_pkg::CFG_CHANNEL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			size_q     <= 4'd5;
			count_q    <= 11'd64;
			alpha_q    <= 24'd336;
			k_q        <= 24'd65536;
			beta_q     <= 16'd3072;
			ci_q       <= '0;
			j_q        <= '0;
			norm_idx_q <= '0;
			pix_last_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_clear) begin
				ci_q    <= '0;
				j_q     <= '0;
				state_q <= ST_IDLE;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							pix_last_q <= last;
							j_q        <= '0;
							if (!last) ci_q <= ci_q + crn_pkg::CI_BITS'(1);
							if (emit_now) begin
								out_last_q <= last && (lag == '0);
								state_q    <= ST_MUL_LO;
							end else if (last) begin
								state_q <= ST_FLUSH;
							end
						end
					end
					ST_MUL_LO: state_q <= ST_MUL_HI;
					ST_MUL_HI: state_q <= ST_SCALE;
					ST_SCALE: begin
						norm_idx_q <= '0;
						state_q    <= ST_NORM;
					end
					ST_NORM: begin
						if (norm_idx_q == 3'd5) state_q <= ST_LOG;
						else norm_idx_q <= norm_idx_q + 3'd1;
					end
					ST_LOG: state_q <= ST_BETA;
					ST_BETA: state_q <= ST_XMUL;
					ST_XMUL: state_q <= ST_OUT;
					ST_OUT: begin
						if (out_free) begin
							if (!pix_last_q) state_q <= ST_IDLE;
							else if (j_q == lag) state_q <= ST_CLEAR;
							else state_q <= ST_FLUSH;
						end
					end
					ST_FLUSH: begin
						j_q <= j_next;
						if (flush_emit) begin
							out_last_q <= (j_next == lag);
							state_q    <= ST_MUL_LO;
						end else if (j_next == lag) begin
							state_q <= ST_CLEAR;
						end
					end
					ST_CLEAR: begin
						ci_q    <= '0;
						j_q     <= '0;
						state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
			if (cfg_valid) begin
				case (cfg_index)
					crn_pkg::CFG_WINDOW_SIZE:   size_q  <= cfg_data[3:0];
					crn_pkg::CFG_CHANNEL_COUNT: count_q <= cfg_data[10:0];
					crn_pkg::CFG_ALPHA:         alpha_q <= cfg_data;
					crn_pkg::CFG_K_OFFSET:      k_q     <= cfg_data;
					crn_pkg::CFG_BETA:          beta_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.push      = in_acc;
		cmd.push_zero = (state_q == ST_FLUSH);
		cmd.load      = (state_q == ST_MUL_LO);
		cmd.mul_hi    = (state_q == ST_MUL_HI);
		cmd.scale     = (state_q == ST_SCALE);
		cmd.norm_step = (state_q == ST_NORM);
		cmd.norm_idx  = norm_idx_q;
		cmd.log_step  = (state_q == ST_LOG);
		cmd.beta_step = (state_q == ST_BETA);
		cmd.xmul      = (state_q == ST_XMUL);
		cmd.out_write = (state_q == ST_OUT) && out_free;
		cmd.out_last  = out_last_q;
		cmd.clear     = (state_q == ST_CLEAR) || cfg_clear;
	end

	assign cfg.size  = eff_size;
	assign cfg.lag   = lag;
	assign cfg.alpha = alpha_q;
	assign cfg.k     = k_q;
	assign cfg.beta  = beta_q;

endmodule

/* design/cross_channel_response_norm.sv */
// top level of the cross-channel local response normalizer
// depends on crn_pkg, crn_if, crn_ctrl and crn_datapath

// usage
// - sample_ch: one signed Q8.8 sample per item, channel 0 first, pixel after pixel
// - result_ch: normalized Q8.8 value per item, last_of_pixel high on the pixel's final result
// - cfg: register writes (index, data), always ready; write only while the block is idle
//   index 0 window size, 1 channel count, 2 alpha/size, 3 k, 4 beta; others ignored
//   writing window size or channel count drops the pixel in progress
// sequence
// - a sample that produces no result, other than a pixel's final channel, leaves the block idle for the next sample
// - a sample that produces a result is pushed, then runs through the shared
//   arithmetic sequence (two partial products, scale, 6 normalize steps, log, beta
//   multiply, exp multiply, rounding) into the result register
// - the final channel of a pixel then pushes lag = size/2 zero channels, each followed
//   by the arithmetic sequence where it releases a result, and a clear step clears the window
// - the result is delayed by lag channels behind the sample stream
// reset clears the window, sum, channel index and loads the default registers
// a stalled receiver holds the result register; the sequencer waits in its last step
// and the next sample is taken once that result has moved on

module cross_channel_response_norm (
	input logic        clk,
	input logic        arst_n,
	crn_in_if.sink     sample_ch,
	crn_out_if.source  result_ch,
	crn_cfg_if.sink    cfg
);

	crn_pkg::crn_cmd_t cmd;
	crn_pkg::crn_cfg_t cfg_vals;
	logic              out_free;

	// registers are always writable
	assign cfg.ready = 1'b1;

	// sequencer and register file
	crn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_free  (out_free),
		.cmd       (cmd),
		.cfg       (cfg_vals)
	);

	// window, arithmetic and result register
	crn_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_vals),
		.sample        (sample_ch.sample),
		.out_ready     (result_ch.ready),
		.out_free      (out_free),
		.out_valid     (result_ch.valid),
		.normalized    (result_ch.normalized),
		.last_of_pixel (result_ch.last_of_pixel)
	);

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_write |-> (!result_ch.valid || result_ch.ready))
		else $error("result register overwritten");

	// after a window clear the block is ready for the next pixel
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> sample_ch.ready)
		else $error("not idle after clear");

	// a sample is never taken while the arithmetic sequence runs
	a_push_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(cmd.load || cmd.out_write || cmd.push_zero))
		else $error("sample taken while busy");

endmodule

/* verif/crn_tb_if.sv */
// result item type shared by the response normalizer testbench
// depends on crn_pkg

package crn_tb_types;
	typedef struct {
		logic signed [crn_pkg::SAMPLE_BITS-1:0] value;
		logic                                   last;
	} norm_result_t;
endpackage

/* verif/testbench.sv */
// testbench of the cross-channel response normalizer: drives samples and register writes,
// predicts each normalized result and checks it field by field with random idling on both sides
// depends on crn_pkg, crn_if, crn_tb_types and the block cross_channel_response_norm

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS  = crn_pkg::SAMPLE_BITS;
	localparam int MAX_WINDOW   = crn_pkg::MAX_WINDOW;
	localparam int MAX_CHANNELS = crn_pkg::MAX_CHANNELS;
	localparam int DELAY_DEPTH  = crn_pkg::DELAY_DEPTH;
	localparam int IDX_BITS     = crn_pkg::CFG_IDX_BITS;
	localparam int DATA_BITS    = crn_pkg::CFG_DATA_BITS;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

	typedef crn_tb_types::norm_result_t result_t;

	// typed-in expectation of one directed row
	typedef struct {
		bit                            has_value;
		logic signed [SAMPLE_BITS-1:0] value;
	} typed_check_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	crn_in_if  sample_ch ();
	crn_out_if result_ch ();
	crn_cfg_if cfg ();

	cross_channel_response_norm u_top (
		.clk(clk), .arst_n(arst_n),
		.sample_ch(sample_ch), .result_ch(result_ch), .cfg(cfg)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of registers and pixel state
	int unsigned win_size, chan_count, alpha_q24, k_q16, beta_q12;
	longint unsigned sq_win [MAX_WINDOW];
	longint          x_delay [DELAY_DEPTH];
	longint unsigned sq_sum;
	int unsigned     chan_idx;
	int unsigned     log_tab [256];
	int unsigned     exp_tab [256];

	result_t expected_q [$];
	typed_check_t typed_q [$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	longint cycles = 0;
	bit hold_req = 1'b0;
	bit hold_active;

	function automatic int unsigned log_bits(longint unsigned m);
		int unsigned r = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			r = r << 1;
			if (m >= 64'h8000_0000) begin
				r = r | 1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	task automatic fill_tables();
		int unsigned lo, hi, mid;
		for (int i = 0; i < 256; i++) begin
			log_tab[i] = log_bits(longint'(256 + i) << 22);
			lo = 65536;
			hi = 131071;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (log_bits(longint'(mid) << 14) >= i * 256) hi = mid;
				else lo = mid + 1;
			end
			exp_tab[i] = lo;
		end
	endtask

	task automatic clear_pixel_state();
		foreach (sq_win[i]) sq_win[i] = 0;
		foreach (x_delay[i]) x_delay[i] = 0;
		sq_sum = 0;
		chan_idx = 0;
	endtask

	task automatic reset_predictor();
		win_size = 5;
		chan_count = 64;
		alpha_q24 = 336;
		k_q16 = 65536;
		beta_q12 = 3072;
		clear_pixel_state();
	endtask

	function automatic int unsigned eff_size();
		if (win_size == 0) return 1;
		return (win_size > MAX_WINDOW) ? MAX_WINDOW : win_size;
	endfunction

	function automatic int unsigned eff_count();
		if (chan_count == 0) return 1;
		return (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : chan_count;
	endfunction

	// floor shift for signed values
	function automatic longint shift_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic void queue_result(result_t r);
		expected_q = {expected_q, r};
	endfunction

	function automatic void queue_typed(bit has_value, logic signed [SAMPLE_BITS-1:0] value);
		typed_check_t t;
		t.has_value = has_value;
		t.value = value;
		typed_q = {typed_q, t};
	endfunction

	task automatic shift_in(longint unsigned sq, longint x, int unsigned size);
		longint unsigned leaving;
		leaving = sq_win[size - 1];
		for (int i = MAX_WINDOW - 1; i > 0; i--) sq_win[i] = sq_win[i - 1];
		sq_win[0] = sq;
		for (int i = DELAY_DEPTH - 1; i > 0; i--) x_delay[i] = x_delay[i - 1];
		x_delay[0] = x;
		sq_sum = sq_sum + sq - leaving;
	endtask

	// x * (k + alpha*sum)^-beta through the log/exp tables
	function automatic result_t normalize(longint x, longint unsigned sum, bit last);
		result_t res;
		longint unsigned s;
		longint lg, z, ip, sh, v, r;
		int unsigned e, f, g;
		longint hi_lim, lo_lim;
		hi_lim = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
		lo_lim = -hi_lim - 1;
		s = longint'(k_q16) + ((longint'(alpha_q24) * sum + (64'd1 << 23)) >> 24);
		if (s == 0) s = 1;
		e = 0;
		while (e < 63 && (s >> (e + 1)) != 0) e++;
		f = (e >= 8) ? int'((s >> (e - 8)) & 255) : int'((s << (8 - e)) & 255);
		lg = (longint'(e) - 16) * 65536 + longint'(log_tab[f]);
		z = shift_floor(-(longint'(beta_q12) * lg) + (64'sd1 <<< 19), 20);
		ip = shift_floor(z, 8);
		g = int'(z & 255);
		if (x == 0) r = 0;
		else if (ip >= 16) r = (x > 0) ? hi_lim : lo_lim;
		else begin
			sh = 16 - ip;
			v = x * longint'(exp_tab[g]);
			r = (sh >= 50) ? 0 : shift_floor(v + (64'sd1 <<< (sh - 1)), int'(sh));
			if (r > hi_lim) r = hi_lim;
			if (r < lo_lim) r = lo_lim;
		end
		res.value = r[SAMPLE_BITS-1:0];
		res.last = last;
		return res;
	endfunction

	// one accepted sample: queue every result it releases
	task automatic predict_sample(logic signed [SAMPLE_BITS-1:0] smp);
		int unsigned size, lag, cnt, ci;
		bit last;
		longint x;
		size = eff_size();
		lag = size - 1 - (size - 1) / 2;
		cnt = eff_count();
		ci = chan_idx;
		last = (ci + 1 >= cnt);
		x = longint'(smp);
		shift_in(longint'(x * x), x, size);
		if (ci >= lag) queue_result(normalize(x_delay[lag], sq_sum, last && lag == 0));
		if (last) begin
			for (int unsigned j = 1; j <= lag; j++) begin
				shift_in(0, 0, size);
				if (ci + j >= lag)
					queue_result(normalize(x_delay[lag], sq_sum, j == lag));
			end
			clear_pixel_state();
		end else begin
			chan_idx = ci + 1;
		end
	endtask

	task automatic predict_write(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] d);
		case (idx)
			crn_pkg::CFG_WINDOW_SIZE: begin
				win_size = d & 32'hF;
				clear_pixel_state();
			end
			crn_pkg::CFG_CHANNEL_COUNT: begin
				chan_count = d & 32'h7FF;
				clear_pixel_state();
			end
			crn_pkg::CFG_ALPHA: alpha_q24 = d;
			crn_pkg::CFG_K_OFFSET: k_q16 = d;
			crn_pkg::CFG_BETA: beta_q12 = d & 32'hFFFF;
			default: ;
		endcase
	endtask

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// register write on the config channel, only called while idle
	// valid is dropped by the next sample or kept for the next write
	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		predict_write(idx, d);
	endtask

	// offer one sample after a random gap; prediction happens at acceptance
	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp);
		int unsigned idle;
		idle = $urandom_range(0, 17);
		cfg.valid <= 1'b0;
		if (idle > 0) begin
			sample_ch.valid <= 1'b0;
			wait_cycles(idle);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= smp;
		do @(posedge clk); while (!sample_ch.ready);
		predict_sample(smp);
		items_sent++;
	endtask

	// wait until every expected result is in, then let the sequencer settle
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		wait_cycles(20);
	endtask

	task automatic set_all(int unsigned ws, int unsigned cc, int unsigned a, int unsigned k,
			int unsigned b);
		write_reg(crn_pkg::CFG_WINDOW_SIZE, DATA_BITS'(ws));
		write_reg(crn_pkg::CFG_CHANNEL_COUNT, DATA_BITS'(cc));
		write_reg(crn_pkg::CFG_ALPHA, DATA_BITS'(a));
		write_reg(crn_pkg::CFG_K_OFFSET, DATA_BITS'(k));
		write_reg(crn_pkg::CFG_BETA, DATA_BITS'(b));
	endtask

	// sample: small magnitudes in half the draws, otherwise full range, zero or an extreme
	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return SAMPLE_BITS'($urandom);
			1: return '0;
			2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
			default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
		endcase
	endfunction

	// directed table: sample, and the expected value where it is obvious (zero samples)
	typedef struct {
		logic signed [SAMPLE_BITS-1:0] smp;
		bit                            known_zero;
	} dir_row_t;

	dir_row_t dir_rows [12] = '{
		'{16'sh0000, 1}, '{16'sh7FFF, 0}, '{16'sh8000, 0}, '{16'sh0100, 0},
		'{16'shFF00, 0}, '{16'sh0001, 0}, '{16'shFFFF, 0}, '{16'sh0000, 1},
		'{16'sh5555, 0}, '{16'shAAAA, 0}, '{16'sh0080, 0}, '{16'sh0000, 1}
	};

	// long receiver hold-off, counted here in cycles
	initial begin
		hold_active = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_active = 1'b1;
		for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
		hold_active = 1'b0;
	end

	// result receiver with random stalls per item
	initial begin
		result_t want;
		typed_check_t chk;
		int unsigned n;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = $urandom_range(0, 17);
			if (n > 0 || hold_active) begin
				result_ch.ready <= 1'b0;
				wait_cycles(n);
				while (hold_active) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d last=%0d",
						result_ch.normalized, result_ch.last_of_pixel);
			end else begin
				want = expected_q.pop_front();
				if (result_ch.normalized !== want.value ||
						result_ch.last_of_pixel !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%0d last=%0d, got value=%0d last=%0d",
							want.value, want.last, result_ch.normalized,
							result_ch.last_of_pixel);
				end
			end
			if (typed_q.size() != 0) begin
				chk = typed_q.pop_front();
				if (chk.has_value && result_ch.normalized !== chk.value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("directed row: expected value=%0d, got value=%0d",
							chk.value, result_ch.normalized);
				end
			end
		end
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// main stimulus
	initial begin
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		fill_tables();
		reset_predictor();
		wait_cycles(7);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: window 3, four-channel pixels, one result per row in order
		set_all(3, 4, 336, 65536, 3072);
		foreach (dir_rows[i]) begin
			queue_typed(dir_rows[i].known_zero, '0);
			send_sample(dir_rows[i].smp);
		end
		drain();

		// even window, short pixel shorter than the lag, gain extremes
		set_all(8, 2, 16777215, 0, 65535);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		drain();
		// zero scale forced to one LSB, beta max: huge gain saturates
		set_all(1, 1, 0, 0, 65535);
		send_sample(16'sh0001);
		send_sample(16'shFFFF);
		send_sample(16'sh0000);
		drain();
		// size zero, count zero, ignored index
		set_all(0, 0, 336, 16777215, 0);
		write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
		send_sample(16'sh1234);
		drain();
		set_all(15, 1024, 100, 65536, 3072);
		send_sample(16'sh0200);
		drain();
		write_reg(crn_pkg::CFG_WINDOW_SIZE, 24'hF);

		// random phases with different settings
		for (int phase = 0; phase < 6; phase++) begin
			set_all($urandom_range(0, 15), $urandom_range(1, 9),
				(phase == 0) ? 24'hFFFFFF : $urandom_range(0, 4000),
				(phase == 1) ? 0 : $urandom_range(0, 24'hFFFFFF),
				$urandom_range(0, 8000));
			if (phase == 2) hold_req = 1'b1;
			for (int n = 0; n < 36; n++) send_sample(rand_sample());
			drain();
		end

		$display("sent %0d samples over directed and six random settings, checked %0d results",
			items_sent, results_seen);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("mismatches: %0d, left over: %0d", mismatches, expected_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
